// ----- hw/rtl/ddq_pkg.sv -----
package ddq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   // request command codes
   localparam logic [2:0] CMD_INS_FRONT = 3'd0;
   localparam logic [2:0] CMD_INS_BACK  = 3'd1;
   localparam logic [2:0] CMD_COUNT     = 3'd2;
   localparam logic [2:0] CMD_DEDUP     = 3'd3;
   localparam logic [2:0] CMD_DUMP      = 3'd4;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // where the response tally and value come from
   localparam logic [1:0] SRC_LEN   = 2'd0;
   localparam logic [1:0] SRC_TALLY = 2'd1;
   localparam logic [1:0] SRC_ITEM  = 2'd2;

   typedef struct packed {
      logic       ins_front;
      logic       ins_back;
      logic       start_pass;
      logic       rd_outer;
      logic       rd_inner;
      logic       cap_v;
      logic       cmp;
      logic       outer_end;
      logic       finish_dedup;
      logic       next_i;
      logic       load_rsp;
      logic [1:0] rsp_status;
      logic [1:0] rsp_src;
      logic       mode_count;
   } ctl_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic i_last;
      logic j_last;
      logic range_zero;
   } ctl_sts_type;

endpackage

// ----- hw/rtl/dedup_deque_store.sv -----
// Bounded double-ended list of 32-bit values with duplicate count and removal.
// Request channel (req_valid/req_ready): command and value. Response channel
// (rsp_valid/rsp_ready): status, item value, tally, last flag.
// One request is worked on at a time; req_ready is high only while idle.
// Insert and unused commands: response valid the cycle after acceptance.
// Count: for n > 0 entries, each outer entry is read from the single-port
// store, then compared against every other entry, with one store read and
// one compare per inner step. Remove-duplicates: the same outer loop, with
// the inner loop only over the entries kept so far, plus a finishing step.
// Count or remove on an empty list answers the next cycle.
// Dump: one response per entry, the next read only after one is taken, the
// last one flagged; an empty list gives one response with status empty.
// A stalled response holds all fields until taken; no new request is taken
// meanwhile. Reset (synchronous) empties the list at once; store contents
// are left as they are and are never read before being written again.
module dedup_deque_store #(
   parameter int DEPTH = ddq_pkg::DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_item_value,
   output logic [4:0]         rsp_tally,
   output logic               rsp_last
);

   ddq_pkg::ctl_cmd_type cmd;
   ddq_pkg::ctl_sts_type sts;

   ddq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd),
      .sts         (sts)
   );

   ddq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_status     (rsp_status),
      .rsp_item_value (rsp_item_value),
      .rsp_tally      (rsp_tally),
      .rsp_last       (rsp_last)
   );

endmodule

// ----- hw/rtl/ddq_ctrl.sv -----
module ddq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_command,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ddq_pkg::ctl_cmd_type  cmd,
   input  ddq_pkg::ctl_sts_type  sts
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ORD  = 4'd1;
   localparam logic [3:0] S_OCAP = 4'd2;
   localparam logic [3:0] S_IRD  = 4'd3;
   localparam logic [3:0] S_ICMP = 4'd4;
   localparam logic [3:0] S_OEND = 4'd5;
   localparam logic [3:0] S_FIN  = 4'd6;
   localparam logic [3:0] S_DRD  = 4'd7;
   localparam logic [3:0] S_DOUT = 4'd8;
   localparam logic [3:0] S_RESP = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       mode_ff, mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP) || (state_ff == S_DOUT);

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      cmd            = '0;
      cmd.mode_count = mode_ff;
      cmd.rsp_status = ddq_pkg::ST_OK;
      cmd.rsp_src    = ddq_pkg::SRC_LEN;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_command)
                  ddq_pkg::CMD_INS_FRONT, ddq_pkg::CMD_INS_BACK: begin
                     cmd.load_rsp = 1'b1;
                     if (sts.full) begin
                        cmd.rsp_status = ddq_pkg::ST_FULL;
                     end else begin
                        cmd.ins_front = (req_command == ddq_pkg::CMD_INS_FRONT);
                        cmd.ins_back  = (req_command == ddq_pkg::CMD_INS_BACK);
                     end
                     state_in = S_RESP;
                  end
                  ddq_pkg::CMD_COUNT, ddq_pkg::CMD_DEDUP: begin
                     mode_in        = (req_command == ddq_pkg::CMD_COUNT);
                     cmd.start_pass = 1'b1;
                     if (sts.empty) begin
                        // nothing to scan: tally and length are both zero
                        cmd.load_rsp = 1'b1;
                        state_in     = S_RESP;
                     end else begin
                        state_in = S_ORD;
                     end
                  end
                  ddq_pkg::CMD_DUMP: begin
                     cmd.start_pass = 1'b1;
                     if (sts.empty) begin
                        cmd.load_rsp   = 1'b1;
                        cmd.rsp_status = ddq_pkg::ST_EMPTY;
                        state_in       = S_RESP;
                     end else begin
                        state_in = S_DRD;
                     end
                  end
                  default: begin
                     cmd.load_rsp = 1'b1;
                     state_in     = S_RESP;
                  end
               endcase
            end
         end
         S_ORD: begin
            cmd.rd_outer = 1'b1;
            state_in     = S_OCAP;
         end
         S_OCAP: begin
            cmd.cap_v = 1'b1;
            state_in  = sts.range_zero ? S_OEND : S_IRD;
         end
         S_IRD: begin
            cmd.rd_inner = 1'b1;
            state_in     = S_ICMP;
         end
         S_ICMP: begin
            cmd.cmp  = 1'b1;
            state_in = sts.j_last ? S_OEND : S_IRD;
         end
         S_OEND: begin
            cmd.outer_end = 1'b1;
            if (!sts.i_last) begin
               state_in = S_ORD;
            end else if (mode_ff) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_src  = ddq_pkg::SRC_TALLY;
               state_in     = S_RESP;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.finish_dedup = 1'b1;
            cmd.load_rsp     = 1'b1;
            state_in         = S_RESP;
         end
         S_DRD: begin
            cmd.rd_outer = 1'b1;
            cmd.load_rsp = 1'b1;
            cmd.rsp_src  = ddq_pkg::SRC_ITEM;
            state_in     = S_DOUT;
         end
         S_DOUT: begin
            if (rsp_ready) begin
               if (sts.i_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.next_i = 1'b1;
                  state_in   = S_DRD;
               end
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/ddq_datapath.sv -----
module ddq_datapath #(
   parameter int DEPTH = ddq_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic signed [31:0]    req_value,
   input  ddq_pkg::ctl_cmd_type  cmd,
   output ddq_pkg::ctl_sts_type  sts,
   output logic [1:0]            rsp_status,
   output logic signed [31:0]    rsp_item_value,
   output logic [4:0]            rsp_tally,
   output logic                  rsp_last
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [31:0]      mem [DEPTH];
   logic [31:0]      rd_data_ff;

   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] i_ff, j_ff, w_ff, tally_ff;
   logic [31:0]      cur_v_ff;
   logic             found_ff;
   logic [1:0]       status_ff, src_ff;

   logic [IDX_W-1:0] front_dec;
   logic [CNT_W-1:0] pos;
   logic [IDX_W:0]   sum;
   logic [IDX_W-1:0] slot;
   logic [IDX_W-1:0] waddr;
   logic             we;
   logic [31:0]      wdata;
   logic [CNT_W-1:0] range;
   logic             match;
   logic [CNT_W-1:0] tally_sel;
   logic [CNT_W+4:0] tally_wide;

   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - IDX_W'(1);

   always_comb begin
      priority if (cmd.ins_back) begin
         pos = count_ff;
      end else if (cmd.rd_inner) begin
         pos = j_ff;
      end else if (cmd.outer_end) begin
         pos = w_ff;
      end else begin
         pos = i_ff;
      end
   end

   // physical slot of a list position: one compare and subtract for the wrap
   always_comb begin
      sum = {1'b0, front_ff} + {1'b0, pos[IDX_W-1:0]};
      if (sum >= (IDX_W + 1)'(DEPTH)) begin
         sum = sum - (IDX_W + 1)'(DEPTH);
      end
      slot = sum[IDX_W-1:0];
   end

   assign we    = cmd.ins_front || cmd.ins_back ||
                  (cmd.outer_end && !cmd.mode_count && !found_ff);
   assign waddr = cmd.ins_front ? front_dec : slot;
   assign wdata = (cmd.ins_front || cmd.ins_back) ? req_value : cur_v_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd_outer || cmd.rd_inner) begin
         rd_data_ff <= mem[slot];
      end
   end

   assign range = cmd.mode_count ? count_ff : w_ff;
   // count compares against every other entry, dedup against kept ones
   assign match = (rd_data_ff == cur_v_ff) && (!cmd.mode_count || (j_ff != i_ff));

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      if (cmd.ins_front) begin
         front_in = front_dec;
      end
      if (cmd.ins_front || cmd.ins_back) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.finish_dedup) begin
         count_in = w_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_pass) begin
         i_ff     <= '0;
         w_ff     <= '0;
         tally_ff <= '0;
      end
      if (cmd.cap_v) begin
         cur_v_ff <= rd_data_ff;
         j_ff     <= '0;
         found_ff <= 1'b0;
      end
      if (cmd.cmp) begin
         j_ff <= j_ff + CNT_W'(1);
         if (match) begin
            found_ff <= 1'b1;
         end
      end
      if (cmd.outer_end) begin
         i_ff <= i_ff + CNT_W'(1);
         if (cmd.mode_count) begin
            tally_ff <= tally_ff + CNT_W'(found_ff);
         end else if (!found_ff) begin
            w_ff <= w_ff + CNT_W'(1);
         end
      end
      if (cmd.next_i) begin
         i_ff <= i_ff + CNT_W'(1);
      end
      if (cmd.load_rsp) begin
         status_ff <= cmd.rsp_status;
         src_ff    <= cmd.rsp_src;
      end
   end

   assign sts.full       = (count_ff == CNT_W'(DEPTH));
   assign sts.empty      = (count_ff == '0);
   assign sts.i_last     = (i_ff == count_ff - CNT_W'(1));
   assign sts.j_last     = (j_ff == range - CNT_W'(1));
   assign sts.range_zero = (range == '0);

   assign tally_sel  = (src_ff == ddq_pkg::SRC_TALLY) ? tally_ff : count_ff;
   assign tally_wide = {5'b0, tally_sel};

   assign rsp_status     = status_ff;
   assign rsp_tally      = tally_wide[4:0];
   assign rsp_item_value = (src_ff == ddq_pkg::SRC_ITEM) ? rd_data_ff : '0;
   assign rsp_last       = (src_ff == ddq_pkg::SRC_ITEM) ? sts.i_last : 1'b1;

endmodule

// ----- hw/rtl/ddq_checker.sv -----
module ddq_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic signed [31:0] rsp_item_value,
   input logic [4:0]         rsp_tally,
   input logic               rsp_last
);

   // one transaction in flight: no request taken while a response is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while response pending");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not idle after reset");

   a_empty_dump: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ddq_pkg::ST_EMPTY)) |->
         (rsp_tally == 5'd0 && rsp_last && rsp_item_value == 32'sd0))
      else $error("empty response malformed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_item_value) &&
          $stable(rsp_tally) && $stable(rsp_last)))
      else $error("stalled response changed");

endmodule

bind dedup_deque_store ddq_checker u_ddq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_item_value (rsp_item_value),
   .rsp_tally      (rsp_tally),
   .rsp_last       (rsp_last)
);
